### design/pwmm_pkg.sv
`default_nettype none
package pwmm_pkg;

  // capture counter width (period and high time)
  localparam int CAP_W   = 16;
  localparam int DUTY_W  = 7;
  localparam int FREQ_W  = 27;
  localparam int TICK_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;

  // high*100 needs seven more bits than a capture
  localparam int DUTY_DIVD_W = CAP_W + DUTY_W;
  localparam int DIV_W       = (FREQ_W > DUTY_DIVD_W) ? FREQ_W : DUTY_DIVD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [DUTY_W-1:0] DUTY_SCALE    = DUTY_W'(100);
  localparam logic [FREQ_W-1:0] CLOCK_RESET   = FREQ_W'(1000000);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1000);

  // input tuser codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_SAMPLE_CLK = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_TIMEOUT    = CIDX_W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### design/pwmm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
module pwmm_div import pwmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [CAP_W-1:0]  divisor,
  output logic      [DIV_W-1:0]  quotient,
  output div_stat_t              stat
);

  logic [DIV_W-1:0]     quot_r;
  logic [CAP_W-1:0]     rem_r;
  logic [CAP_W-1:0]     dvsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [CAP_W:0]       trial;
  logic [CAP_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, quot_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign ge    = trial >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
      quot_r <= {quot_r[DIV_W-2:0], ge};
    end
  end

  assign quotient  = quot_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule
`default_nettype wire

### design/pwm_input_duty_frequency_meter.sv
`default_nettype none
// PWM input meter. Each input transfer is either a capture (tuser = 0: period and
// high-time counts) or a one-millisecond tick (tuser = 1), and each one produces
// exactly one result transfer with the current duty percent, frequency in hertz
// and a fresh flag; once the timeout has run out the readings show zero. A capture
// with a nonzero period runs two bit-serial restoring dividers side by side
// (high*100/period and sample_clock_hz/period), one quotient bit per cycle over
// the 27-bit dividend, before the result is loaded; a tick or a zero-period capture
// goes to the result load with no division. One item is in work at a time; the
// result sits in an output register until taken. Configuration writes are taken at
// any time but must only be issued while the block is idle.
module pwm_input_duty_frequency_meter import pwmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [2*CAP_W-1:0] in_tdata,  // period_count, high_count
  input  wire logic              in_tuser,   // cmd: 0 capture, 1 tick
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // duty_percent, frequency_hz, zero pad
  output logic                   out_tuser,  // fresh
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [FREQ_W-1:0] sample_clk_r;
  logic [TICK_W-1:0] timeout_r;
  logic [DUTY_W-1:0] duty_r;
  logic [FREQ_W-1:0] freq_r;
  logic [TICK_W-1:0] ticks_r;
  logic              clamp_r;
  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;
  logic              out_tuser_r;

  logic [CAP_W-1:0]       period;
  logic [CAP_W-1:0]       high;
  logic                   in_xfer;
  logic                   div_start;
  logic [DUTY_DIVD_W-1:0] high_x100;
  logic [DIV_W-1:0]       duty_q;
  logic [DIV_W-1:0]       freq_q;
  div_stat_t              duty_stat;
  div_stat_t              freq_stat;
  logic                   out_free;
  logic                   fresh;

  assign period = in_tdata[CAP_W-1:0];
  assign high   = in_tdata[2*CAP_W-1:CAP_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign div_start = in_xfer && (in_tuser == CMD_CAPTURE) && (period != '0);
  assign cfg_ready = 1'b1;

  // high * 100 = high*64 + high*32 + high*4
  assign high_x100 = {1'b0, high, 6'b0} + {2'b0, high, 5'b0} + {5'b0, high, 2'b0};

  pwmm_div u_div_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(high_x100)),
    .divisor  (period),
    .quotient (duty_q),
    .stat     (duty_stat)
  );

  pwmm_div u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(sample_clk_r)),
    .divisor  (period),
    .quotient (freq_q),
    .stat     (freq_stat)
  );

  assign out_free = !out_tvalid_r || out_tready;
  assign fresh    = (ticks_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else if (in_xfer) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DIV: begin
        if (duty_stat.done && freq_stat.done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sample_clk_r <= CLOCK_RESET;
      timeout_r    <= TIMEOUT_RESET;
      duty_r       <= '0;
      freq_r       <= '0;
      ticks_r      <= TIMEOUT_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_CLK) begin
          sample_clk_r <= cfg_data[FREQ_W-1:0];
        end else if (cfg_index == REG_TIMEOUT) begin
          timeout_r <= cfg_data[TICK_W-1:0];
        end
      end

      if (in_xfer) begin
        if (in_tuser == CMD_CAPTURE) begin
          // every capture reloads the timeout
          ticks_r <= timeout_r;
          if (period == '0) begin
            duty_r <= '0;
            freq_r <= '0;
          end
        end else if (ticks_r != '0) begin
          ticks_r <= ticks_r - TICK_W'(1);
        end
      end

      if (state_r == ST_DIV && duty_stat.done && freq_stat.done) begin
        duty_r <= clamp_r ? DUTY_SCALE : duty_q[DUTY_W-1:0];
        freq_r <= freq_q[FREQ_W-1:0];
      end

      if (state_r == ST_LOAD && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      // high >= period means the duty reaches or passes 100
      clamp_r <= (high >= period);
    end
    if (state_r == ST_LOAD && out_free) begin
      out_tdata_r <= fresh ? {6'b0, freq_r, duty_r} : '0;
      out_tuser_r <= fresh;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

### design/pwmm_chk.sv
`default_nettype none
module pwmm_chk import pwmm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [39:0]        out_tdata,
  input wire logic               out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // stale readings show zero
  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("stale result not zero");

  // duty never above 100
  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DUTY_W-1:0] <= DUTY_SCALE)
    else $error("duty above 100");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

endmodule

bind pwm_input_duty_frequency_meter pwmm_chk u_pwmm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
